// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check is sampled on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A check that is skipped while the synchronous reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A check that must also hold during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/cdt_pkg.sv =====
`timescale 1ns / 1ps

package cdt_pkg;

    // Key and tick codes carried in the mode field of an input item.
    typedef enum logic [2:0] {
        MODE_TICK        = 3'd0,
        MODE_DIGIT       = 3'd1,
        MODE_BACK        = 3'd2,
        MODE_ENTER       = 3'd3,
        MODE_CANCEL      = 3'd4,
        MODE_START_PAUSE = 3'd5,
        MODE_SET         = 3'd6,
        MODE_RESET       = 3'd7
    } t_mode;

    localparam int ENTRY_DIGITS = 6;
    localparam int ENTRY_CNT_W  = 3;
    localparam int DIGIT_W      = 4;
    localparam int BCD_W        = ENTRY_DIGITS * DIGIT_W;

    localparam int HOUR_W = 7;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int MS_W   = 10;

    localparam logic [MS_W-1:0]  MS_PER_SEC  = 10'd1000;
    localparam logic [MS_W-1:0]  MS_MAX      = 10'd999;
    localparam logic [SEC_W-1:0] SEC_MAX     = 6'd59;
    localparam logic [MIN_W-1:0] MIN_MAX     = 6'd59;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    // A tens digit below this keeps a two-digit field under 60.
    localparam logic [DIGIT_W-1:0] TENS_LIMIT = 4'd6;

    typedef struct packed {
        t_mode             mode;
        logic [DIGIT_W-1:0] digit;
        logic [MS_W-1:0]   elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [HOUR_W-1:0]      hours;
        logic [MIN_W-1:0]       minutes;
        logic [SEC_W-1:0]       seconds;
        logic [MS_W-1:0]        millis;
        logic                   running;
        logic                   finished;
        logic                   entering;
        logic [ENTRY_CNT_W-1:0] digits_entered;
        logic [BCD_W-1:0]       entry_bcd;
    } t_out_item;

endpackage

// ===== rtl/countdown_timer_with_keypad_entry.sv =====
`timescale 1ns / 1ps
// The result of an item is registered and is valid on o_out_valid in the cycle after it is accepted.
// Throughput: one item per cycle unless o_in_stall is high; the single-pass update sets it.
// The result register is the timer state itself, so it frees as the result is taken.
// Reset (synchronous, active low) clears the time, the flags, the entry and the result valid.
`include "assert_macros.svh"

module countdown_timer_with_keypad_entry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cdt_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cdt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    // Timer state. After every accepted item these registers hold exactly the
    // values the result item reports, so they double as the result register.
    logic [cdt_pkg::HOUR_W-1:0]      r_hour, n_hour;
    logic [cdt_pkg::MIN_W-1:0]       r_min, n_min;
    logic [cdt_pkg::SEC_W-1:0]       r_sec, n_sec;
    logic [cdt_pkg::MS_W-1:0]        r_ms, n_ms;
    logic                            r_run, n_run;
    logic                            r_done, n_done;
    logic                            r_entry_open, n_entry_open;
    logic [cdt_pkg::ENTRY_CNT_W-1:0] r_entry_count, n_entry_count;
    logic [cdt_pkg::DIGIT_W-1:0]     r_digit [cdt_pkg::ENTRY_DIGITS];
    logic [cdt_pkg::DIGIT_W-1:0]     n_digit [cdt_pkg::ENTRY_DIGITS];
    logic                            r_out_valid, n_out_valid;

    logic in_accept;

    // Tick datapath.
    logic [cdt_pkg::MS_W-1:0]   el_sat;
    logic [cdt_pkg::MS_W:0]     ms_diff;
    logic                       ms_borrow;
    logic [cdt_pkg::MS_W-1:0]   tk_ms;
    logic                       hm_nonzero;
    logic                       sec_under;
    logic [cdt_pkg::HOUR_W-1:0] tk_hour;
    logic [cdt_pkg::MIN_W-1:0]  tk_min;
    logic [cdt_pkg::SEC_W-1:0]  tk_sec;
    logic                       tk_finish;

    // Entry load datapath.
    logic [cdt_pkg::HOUR_W-1:0] ld_hour;
    logic [cdt_pkg::MIN_W-1:0]  ld_min;
    logic [cdt_pkg::SEC_W-1:0]  ld_sec;
    logic                       ld_ok;
    logic                       hms_nonzero;

    // Two decimal digits to binary; times ten is a shift-and-add.
    function automatic logic [cdt_pkg::HOUR_W-1:0] two_digits(
        input logic [cdt_pkg::DIGIT_W-1:0] tens,
        input logic [cdt_pkg::DIGIT_W-1:0] ones
    );
        logic [cdt_pkg::HOUR_W-1:0] t;
        t = cdt_pkg::HOUR_W'(tens);
        return (t << 3) + (t << 1) + cdt_pkg::HOUR_W'(ones);
    endfunction

    // The next item can enter whenever the current result is gone or is being taken.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // A tick subtracts the saturated elapsed time and borrows at most once per field.
    always_comb begin
        el_sat    = (i_in_data.elapsed_ms > cdt_pkg::MS_MAX) ? cdt_pkg::MS_MAX
                                                             : i_in_data.elapsed_ms;
        ms_diff   = {1'b0, r_ms} - {1'b0, el_sat};
        ms_borrow = ms_diff[cdt_pkg::MS_W];
        // Negative differences wrap back into range once 1000 is added.
        tk_ms     = ms_borrow ? (ms_diff[cdt_pkg::MS_W-1:0] + cdt_pkg::MS_PER_SEC)
                              : ms_diff[cdt_pkg::MS_W-1:0];

        hm_nonzero = (r_hour != '0) || (r_min != '0);
        sec_under  = ms_borrow && (r_sec == '0);

        tk_hour = r_hour;
        tk_min  = r_min;
        tk_sec  = r_sec - cdt_pkg::SEC_W'(ms_borrow);
        if (sec_under) begin
            if (hm_nonzero) begin
                tk_sec = cdt_pkg::SEC_MAX;
                if (r_min == '0) begin
                    // Minutes borrow from hours, which are known to be nonzero here.
                    tk_min  = cdt_pkg::MIN_MAX;
                    tk_hour = r_hour - 1'b1;
                end else begin
                    tk_min = r_min - 1'b1;
                end
            end else begin
                // Nothing left to borrow from: the countdown has run out.
                tk_sec = '0;
            end
        end
        tk_finish = (tk_hour == '0) && (tk_min == '0) && (tk_sec == '0);
    end

    // The typed HHMMSS value; minutes and seconds are valid when their tens digit is below 6.
    always_comb begin
        ld_hour     = two_digits(r_digit[0], r_digit[1]);
        ld_min      = cdt_pkg::MIN_W'(two_digits(r_digit[2], r_digit[3]));
        ld_sec      = cdt_pkg::SEC_W'(two_digits(r_digit[4], r_digit[5]));
        ld_ok       = (r_digit[2] < cdt_pkg::TENS_LIMIT) && (r_digit[4] < cdt_pkg::TENS_LIMIT);
        hms_nonzero = (r_hour != '0) || (r_min != '0) || (r_sec != '0);
    end

    // Next state for one accepted item.
    always_comb begin
        n_hour        = r_hour;
        n_min         = r_min;
        n_sec         = r_sec;
        n_ms          = r_ms;
        n_run         = r_run;
        n_done        = r_done;
        n_entry_open  = r_entry_open;
        n_entry_count = r_entry_count;
        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
            n_digit[i] = r_digit[i];
        end
        n_out_valid = r_out_valid && i_out_stall;

        if (in_accept) begin
            n_out_valid = 1'b1;
            unique case (i_in_data.mode)
                cdt_pkg::MODE_TICK: begin
                    // Ticks count whether or not the entry is open, but only while running.
                    if (r_run) begin
                        if (tk_finish) begin
                            n_hour = '0;
                            n_min  = '0;
                            n_sec  = '0;
                            n_ms   = '0;
                            n_run  = 1'b0;
                            n_done = 1'b1;
                        end else begin
                            n_hour = tk_hour;
                            n_min  = tk_min;
                            n_sec  = tk_sec;
                            n_ms   = tk_ms;
                        end
                    end
                end
                cdt_pkg::MODE_DIGIT: begin
                    // Digits above nine and digits past a full entry are dropped.
                    if (r_entry_open && (i_in_data.digit <= cdt_pkg::DIGIT_MAX)
                            && (r_entry_count < cdt_pkg::ENTRY_CNT_W'(cdt_pkg::ENTRY_DIGITS))) begin
                        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                            if (r_entry_count == cdt_pkg::ENTRY_CNT_W'(i)) begin
                                n_digit[i] = i_in_data.digit;
                            end
                        end
                        n_entry_count = r_entry_count + 1'b1;
                    end
                end
                cdt_pkg::MODE_BACK: begin
                    if (r_entry_open && (r_entry_count != '0)) begin
                        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                            if (r_entry_count == cdt_pkg::ENTRY_CNT_W'(i + 1)) begin
                                n_digit[i] = '0;
                            end
                        end
                        n_entry_count = r_entry_count - 1'b1;
                    end
                end
                cdt_pkg::MODE_ENTER: begin
                    // Enter waits for all six digits; a bad MM or SS closes the entry unused.
                    if (r_entry_open
                            && (r_entry_count == cdt_pkg::ENTRY_CNT_W'(cdt_pkg::ENTRY_DIGITS))) begin
                        if (ld_ok) begin
                            n_hour = ld_hour;
                            n_min  = ld_min;
                            n_sec  = ld_sec;
                            n_done = 1'b0;
                        end
                        n_entry_open  = 1'b0;
                        n_entry_count = '0;
                        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                            n_digit[i] = '0;
                        end
                    end
                end
                cdt_pkg::MODE_CANCEL: begin
                    if (r_entry_open) begin
                        n_entry_open  = 1'b0;
                        n_entry_count = '0;
                        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                            n_digit[i] = '0;
                        end
                    end
                end
                cdt_pkg::MODE_START_PAUSE: begin
                    // Toggling needs some whole seconds left; leftover milliseconds do not count.
                    if (!r_entry_open && hms_nonzero) begin
                        n_run  = !r_run;
                        n_done = 1'b0;
                    end
                end
                cdt_pkg::MODE_SET: begin
                    // Opening the entry stops the timer but keeps the finished flag.
                    if (!r_entry_open) begin
                        n_entry_open  = 1'b1;
                        n_entry_count = '0;
                        n_run         = 1'b0;
                        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                            n_digit[i] = '0;
                        end
                    end
                end
                cdt_pkg::MODE_RESET: begin
                    // Milliseconds survive the reset key.
                    if (!r_entry_open) begin
                        n_run  = 1'b0;
                        n_hour = '0;
                        n_min  = '0;
                        n_sec  = '0;
                        n_done = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour        <= '0;
            r_min         <= '0;
            r_sec         <= '0;
            r_ms          <= '0;
            r_run         <= 1'b0;
            r_done        <= 1'b0;
            r_entry_open  <= 1'b0;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else begin
            r_hour        <= n_hour;
            r_min         <= n_min;
            r_sec         <= n_sec;
            r_ms          <= n_ms;
            r_run         <= n_run;
            r_done        <= n_done;
            r_entry_open  <= n_entry_open;
            r_entry_count <= n_entry_count;
            r_out_valid   <= n_out_valid;
            for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
                r_digit[i] <= n_digit[i];
            end
        end
    end

    // The result item is read straight off the state. The first digit sits in the
    // top nibble, and only typed positions are shown.
    always_comb begin
        o_out_data.hours          = r_hour;
        o_out_data.minutes        = r_min;
        o_out_data.seconds        = r_sec;
        o_out_data.millis         = r_ms;
        o_out_data.running        = r_run;
        o_out_data.finished       = r_done;
        o_out_data.entering       = r_entry_open;
        o_out_data.digits_entered = r_entry_count;
        o_out_data.entry_bcd      = '0;
        for (int i = 0; i < cdt_pkg::ENTRY_DIGITS; i++) begin
            if (cdt_pkg::ENTRY_CNT_W'(i) < r_entry_count) begin
                o_out_data.entry_bcd[cdt_pkg::BCD_W-1-cdt_pkg::DIGIT_W*i -: cdt_pkg::DIGIT_W] =
                    r_digit[i];
            end
        end
    end

    // The timer can never be counting and finished at once.
    `ASSERT_CLK(a_run_not_done, !(r_run && r_done), "timer running while finished")
    // Stored minutes and seconds stay in range through every borrow and load.
    `ASSERT_CLK(a_min_sec_range,
        (r_min <= cdt_pkg::MIN_MAX) && (r_sec <= cdt_pkg::SEC_MAX),
        "minutes or seconds out of range")
    // A closed entry holds no typed digits, and the count never passes six.
    `ASSERT_CLK(a_entry_count,
        (r_entry_open || (r_entry_count == '0))
            && (r_entry_count <= cdt_pkg::ENTRY_CNT_W'(cdt_pkg::ENTRY_DIGITS)),
        "entry count inconsistent")
    // Without an accepted item the state must hold still.
    `ASSERT_CLK(a_state_hold,
        !in_accept |=> $stable(r_hour) && $stable(r_min) && $stable(r_sec)
            && $stable(r_ms) && $stable(r_entry_count),
        "state moved without an item")

endmodule

// ===== test/timer_state_checker.sv =====
`timescale 1ns / 1ps

module timer_state_checker
    import cdt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // Sixty seconds to the minute and sixty minutes to the hour.
    localparam int UNITS_PER_NEXT = 60;

    int                 hour_q;
    int                 min_q;
    int                 sec_q;
    int                 ms_q;
    logic               run_q;
    logic               done_q;
    logic               entry_on;
    int                 entry_cnt;
    logic [DIGIT_W-1:0] entry_dig [ENTRY_DIGITS];
    t_out_item          expected_display_q [$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void clear_entry();
        entry_on  = 1'b0;
        entry_cnt = 0;
        foreach (entry_dig[i]) entry_dig[i] = '0;
    endfunction

    // Applies one item to the timer state and returns the display that follows it.
    function automatic t_out_item next_timer_state(input t_in_item it);
        t_out_item res;
        int        ms_step;
        int        d_hh;
        int        d_mm;
        int        d_ss;
        if (it.mode == MODE_TICK) begin
            if (run_q) begin
                ms_step = (it.elapsed_ms > MS_MAX) ? int'(MS_MAX) : int'(it.elapsed_ms);
                ms_q = ms_q - ms_step;
                if (ms_q < 0) begin
                    sec_q = sec_q - 1;
                    ms_q  = ms_q + int'(MS_PER_SEC);
                end
                if (sec_q < 0 && (min_q > 0 || hour_q > 0)) begin
                    min_q = min_q - 1;
                    sec_q = sec_q + UNITS_PER_NEXT;
                end
                if (min_q < 0 && hour_q > 0) begin
                    hour_q = hour_q - 1;
                    min_q  = min_q + UNITS_PER_NEXT;
                end
                if (hour_q <= 0 && min_q <= 0 && sec_q <= 0) begin
                    hour_q = 0;
                    min_q  = 0;
                    sec_q  = 0;
                    ms_q   = 0;
                    run_q  = 1'b0;
                    done_q = 1'b1;
                end
            end
        end else if (entry_on) begin
            case (it.mode)
                MODE_DIGIT: begin
                    if (it.digit <= DIGIT_MAX && entry_cnt < ENTRY_DIGITS) begin
                        entry_dig[entry_cnt] = it.digit;
                        entry_cnt = entry_cnt + 1;
                    end
                end
                MODE_BACK: begin
                    if (entry_cnt > 0) begin
                        entry_cnt = entry_cnt - 1;
                        entry_dig[entry_cnt] = '0;
                    end
                end
                MODE_ENTER: begin
                    if (entry_cnt == ENTRY_DIGITS) begin
                        d_hh = int'(entry_dig[0]) * 10 + int'(entry_dig[1]);
                        d_mm = int'(entry_dig[2]) * 10 + int'(entry_dig[3]);
                        d_ss = int'(entry_dig[4]) * 10 + int'(entry_dig[5]);
                        if (d_mm < UNITS_PER_NEXT && d_ss < UNITS_PER_NEXT) begin
                            hour_q = d_hh;
                            min_q  = d_mm;
                            sec_q  = d_ss;
                            done_q = 1'b0;
                        end
                        clear_entry();
                    end
                end
                MODE_CANCEL: clear_entry();
                default: ;
            endcase
        end else begin
            case (it.mode)
                MODE_START_PAUSE: begin
                    if (hour_q > 0 || min_q > 0 || sec_q > 0) begin
                        run_q  = !run_q;
                        done_q = 1'b0;
                    end
                end
                MODE_SET: begin
                    clear_entry();
                    entry_on = 1'b1;
                    run_q    = 1'b0;
                end
                MODE_RESET: begin
                    run_q  = 1'b0;
                    hour_q = 0;
                    min_q  = 0;
                    sec_q  = 0;
                    done_q = 1'b0;
                end
                default: ;
            endcase
        end

        res                = '0;
        res.hours          = hour_q[HOUR_W-1:0];
        res.minutes        = min_q[MIN_W-1:0];
        res.seconds        = sec_q[SEC_W-1:0];
        res.millis         = ms_q[MS_W-1:0];
        res.running        = run_q;
        res.finished       = done_q;
        res.entering       = entry_on;
        res.digits_entered = entry_cnt[ENTRY_CNT_W-1:0];
        for (int i = 0; i < ENTRY_DIGITS; i++) begin
            if (i < entry_cnt) begin
                res.entry_bcd[BCD_W-1-DIGIT_W*i -: DIGIT_W] = entry_dig[i];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Results are taken before the new item is applied, since an item and the
    // result of the one before it can be accepted at the same edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            hour_q = 0;
            min_q  = 0;
            sec_q  = 0;
            ms_q   = 0;
            run_q  = 1'b0;
            done_q = 1'b0;
            clear_entry();
            expected_display_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_display_q.size() == 0) begin
                    $error("result item arrived with no item pending");
                    fail_count++;
                end else begin
                    want = expected_display_q.pop_front();
                    check_field("hours", want.hours, i_out_data.hours);
                    check_field("minutes", want.minutes, i_out_data.minutes);
                    check_field("seconds", want.seconds, i_out_data.seconds);
                    check_field("millis", want.millis, i_out_data.millis);
                    check_field("running", want.running, i_out_data.running);
                    check_field("finished", want.finished, i_out_data.finished);
                    check_field("entering", want.entering, i_out_data.entering);
                    check_field("digits_entered", want.digits_entered,
                                i_out_data.digits_entered);
                    check_field("entry_bcd", want.entry_bcd, i_out_data.entry_bcd);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_display_q.push_back(next_timer_state(i_in_data));
            end
            o_pending <= expected_display_q.size();
        end
    end

endmodule

// ===== test/tb_countdown_timer_with_keypad_entry.sv =====
`timescale 1ns / 1ps

module tb_countdown_timer_with_keypad_entry;
    import cdt_pkg::*;

    // Roughly this many random items follow the directed opening, spread over
    // four idling phases.
    localparam int RANDOM_ITEMS = 1850;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES  = 200;
    // Cycles allowed after the last result for any stray output to show up.
    localparam int SETTLE_CYCLES = 8;

    // Clock, reset and the two channels. Every input of the block has a known
    // value from time zero.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    int fail_count;
    int pending;

    // Idling knobs. The sender idles before an item with the first probability,
    // the receiver stalls each cycle with the second, both in percent.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    // The stimulus asks for a long hold-off by bumping hold_req; the receiver
    // process notices the change on a later edge and counts the hold down itself.
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    countdown_timer_with_keypad_entry dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    timer_state_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard limit on the run, set with a wide margin over the slowest legal run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls at the current rate, or a solid stall while a
    // requested hold-off is being counted down.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Builds an item. The value lands in elapsed_ms for a tick and in digit for
    // a digit key; every field the mode does not use gets random content, so
    // the block is also shown that it must ignore them.
    function automatic t_in_item key_item(input t_mode m, input int value);
        t_in_item it;
        it.mode       = m;
        it.digit      = DIGIT_W'($urandom_range(15));
        it.elapsed_ms = MS_W'($urandom_range(1023));
        if (m == MODE_TICK) begin
            it.elapsed_ms = value[MS_W-1:0];
        end else if (m == MODE_DIGIT) begin
            it.digit = value[DIGIT_W-1:0];
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays
    // high on return, so the next call either idles or overwrites the payload
    // with a single assignment in that same time step.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Sender pause: nothing is offered until every result owed has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // One well-formed session: open the entry, type a time (with the odd
    // correction, rejected key or overflow digit), commit or cancel it, then
    // start the count and feed ticks with a few stray keys mixed in. Times are
    // mostly a few seconds so that many sessions run all the way to finished,
    // while some carry hours and minutes to exercise the borrow chain and some
    // hold minutes or seconds of 60 or more so that the commit is refused.
    task automatic program_and_run();
        int hh;
        int mm;
        int ss;
        int pick;
        int typed [ENTRY_DIGITS];
        hh = ($urandom_range(99) < 70) ? 0 : $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 60) begin
            mm = 0;
        end else if (pick < 85) begin
            mm = $urandom_range(59);
        end else begin
            mm = $urandom_range(60, 99);
        end
        ss = ($urandom_range(99) < 70) ? $urandom_range(9) : $urandom_range(99);
        typed = '{hh / 10, hh % 10, mm / 10, mm % 10, ss / 10, ss % 10};

        send_item(key_item(MODE_SET, 0));
        foreach (typed[i]) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_item(key_item(MODE_DIGIT, $urandom_range(10, 15)));
            end else if (pick < 12) begin
                send_item(key_item(MODE_DIGIT, $urandom_range(9)));
                send_item(key_item(MODE_BACK, 0));
            end else if (pick < 15) begin
                send_item(key_item(MODE_ENTER, 0));
            end
            send_item(key_item(MODE_DIGIT, typed[i]));
        end
        if ($urandom_range(99) < 10) begin
            send_item(key_item(MODE_DIGIT, $urandom_range(9)));
        end
        if ($urandom_range(99) < 8) begin
            send_item(key_item(MODE_CANCEL, 0));
        end else begin
            send_item(key_item(MODE_ENTER, 0));
        end
        if ($urandom_range(99) < 8) begin
            send_item(key_item(MODE_RESET, 0));
        end
        send_item(key_item(MODE_START_PAUSE, 0));

        repeat ($urandom_range(2, 30)) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_item(key_item(MODE_START_PAUSE, 0));
            end else if (pick < 6) begin
                send_item(key_item(MODE_RESET, 0));
            end else if (pick < 8) begin
                send_item(key_item(MODE_SET, 0));
            end else if (pick < 10) begin
                send_item(key_item(MODE_CANCEL, 0));
            end else if (pick < 18) begin
                // Elapsed values past 999 are clamped by the block.
                send_item(key_item(MODE_TICK, $urandom_range(1000, 1023)));
            end else begin
                send_item(key_item(MODE_TICK, $urandom_range(999)));
            end
        end
    endtask

    // Unstructured items: any mode, any digit, any elapsed value.
    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            send_item(key_item(t_mode'($urandom_range(7)), $urandom_range(1023)));
        end
    endtask

    initial begin
        int phase_end;
        int saved_idle;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. A tick while stopped does nothing, start with no
        // time does nothing, and entry keys with the entry closed are ignored.
        send_item(key_item(MODE_TICK, 1023));
        send_item(key_item(MODE_START_PAUSE, 0));
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_BACK, 0));
        send_item(key_item(MODE_ENTER, 0));
        send_item(key_item(MODE_CANCEL, 0));
        // Open the entry: a digit above nine, backspace on an empty entry, an
        // early enter and a timer key are all ignored while it is open.
        send_item(key_item(MODE_SET, 0));
        send_item(key_item(MODE_DIGIT, 15));
        send_item(key_item(MODE_BACK, 0));
        send_item(key_item(MODE_ENTER, 0));
        send_item(key_item(MODE_START_PAUSE, 0));
        // Type the largest legal time, try a seventh digit, correct the last
        // digit with backspace and commit 99:59:59.
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_DIGIT, 5));
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_DIGIT, 5));
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_DIGIT, 3));
        send_item(key_item(MODE_BACK, 0));
        send_item(key_item(MODE_DIGIT, 9));
        send_item(key_item(MODE_ENTER, 0));
        // Run and tick with an out-of-range elapsed value, which clamps to 999
        // and leaves one millisecond behind.
        send_item(key_item(MODE_START_PAUSE, 0));
        send_item(key_item(MODE_TICK, 1000));
        // Reset keeps that millisecond; start with only milliseconds left is
        // then refused.
        send_item(key_item(MODE_RESET, 0));
        send_item(key_item(MODE_START_PAUSE, 0));
        wait_for_results();

        // Random part: no idling, sender idling, receiver stalling, then both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end) begin
                if ($urandom_range(99) < 15) begin
                    send_noise();
                end else begin
                    program_and_run();
                end
            end

            // After the sender-idle phase, hold the receiver off for a long
            // stretch while the sender offers items back to back, so the block
            // fills and stalls its input; then wait for it to drain.
            if (phase == 1) begin
                saved_idle    = send_idle_pct;
                send_idle_pct = 0;
                hold_req     <= hold_req + 1;
                repeat (24) begin
                    send_item(key_item(t_mode'($urandom_range(7)), $urandom_range(1023)));
                end
                send_idle_pct = saved_idle;
            end
            wait_for_results();
        end

        // Let any stray output appear before the verdict.
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
